[sv/tmd_pkg.sv]
// shared types and constants for the table-driven morse decoder
// no dependencies; imported by tmd_table, tmd_ctrl and the top level
`default_nettype none

package tmd_pkg;

  localparam int unsigned LetterW  = 5;
  localparam int unsigned PatternW = 32;
  localparam int unsigned LengthW  = 6;
  localparam int unsigned FieldIdxW = 6;

  localparam logic [LetterW-1:0] LAST_LETTER  = 5'd25;
  localparam logic [LetterW-1:0] UNKNOWN_CODE = 5'd26;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SYMBOL = 1'b1;

  typedef enum logic [1:0] {
    SYM_DOT  = 2'd0,
    SYM_DASH = 2'd1,
    SYM_SEP  = 2'd2,
    SYM_END  = 2'd3
  } tmd_sym_e;

  // one table write as taken from the input stream
  typedef struct packed {
    logic                 en;
    logic [FieldIdxW-1:0] idx;
    logic [LetterW-1:0]   letter;
    logic [PatternW-1:0]  pattern;
    logic [LengthW-1:0]   length;
  } tmd_wr_t;

  // one stored table entry
  typedef struct packed {
    logic [LetterW-1:0]  letter;
    logic [PatternW-1:0] pattern;
    logic [LengthW-1:0]  length;
  } tmd_entry_t;

  // registered read data of the table
  typedef struct packed {
    logic       valid;
    tmd_entry_t entry;
  } tmd_rd_t;

  function automatic logic [PatternW-1:0] low_mask(input logic [LengthW-1:0] n);
    logic [PatternW-1:0] m;
    if (n >= LengthW'(PatternW)) begin
      m = '1;
    end else begin
      m = (PatternW'(1) << n) - PatternW'(1);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[sv/tmd_table.sv]
// code table: synchronous entry memory with one read port and valid flops
// depends on tmd_pkg
`default_nettype none

module tmd_table
  import tmd_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64,
  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire tmd_wr_t         wr_i,
  input  wire logic [IdxW-1:0] rd_addr_i,
  output tmd_rd_t              rd_o
);

  tmd_entry_t               mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic                     rd_valid_q;
  tmd_entry_t               rd_entry_q;

  logic            wr_in_range;
  logic [IdxW-1:0] wr_addr;
  tmd_entry_t      wr_entry;

  assign wr_in_range = 32'(wr_i.idx) < TABLE_ENTRIES;
  assign wr_addr     = IdxW'(wr_i.idx);

  always_comb begin
    wr_entry.letter  = (wr_i.letter > LAST_LETTER) ? UNKNOWN_CODE : wr_i.letter;
    wr_entry.pattern = wr_i.pattern & low_mask(wr_i.length);
    wr_entry.length  = wr_i.length;
  end

  // zero length only clears the valid mark, the entry itself is kept
  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_in_range && (wr_i.length != '0)) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_entry_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.en && wr_in_range) begin
        valid_q[wr_addr] <= (wr_i.length != '0);
      end
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_o.valid = rd_valid_q;
  assign rd_o.entry = rd_entry_q;

endmodule

`default_nettype wire

[sv/tmd_ctrl.sv]
// symbol collection, table scan sequencer and output register
// depends on tmd_pkg; drives the read port of tmd_table
`default_nettype none

module tmd_ctrl
  import tmd_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned MAX_SYMBOLS   = 32,
  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  output logic                    in_ready_o,
  input  wire logic               sym_valid_i,
  input  wire logic [1:0]         symbol_i,
  output logic [IdxW-1:0]         rd_addr_o,
  input  wire tmd_rd_t            rd_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [LetterW-1:0]      out_letter_o,
  output logic                    out_last_o
);

  localparam int unsigned CntW     = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned SymLimit = (MAX_SYMBOLS < 32) ? MAX_SYMBOLS : 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT
  } state_e;

  state_e              state_q;
  logic [PatternW-1:0] pend_pat_q;
  logic [LengthW-1:0]  pend_len_q;
  logic                ovf_q;
  logic [CntW-1:0]     ra_q;
  logic                cmp_q;
  logic [LetterW-1:0]  res_q;
  logic                end_q;
  logic                out_valid_q;
  logic [LetterW-1:0]  out_letter_q;
  logic                out_last_q;

  logic hit;
  logic ra_in_table;
  logic out_load;

  assign ra_in_table = ra_q < CntW'(TABLE_ENTRIES);
  assign hit = rd_i.valid && (rd_i.entry.length == pend_len_q)
               && (rd_i.entry.pattern == pend_pat_q);
  // result moves into the output register when it is free or being drained
  assign out_load = (state_q == ST_WAIT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pend_pat_q   <= '0;
      pend_len_q   <= '0;
      ovf_q        <= 1'b0;
      ra_q         <= '0;
      cmp_q        <= 1'b0;
      res_q        <= '0;
      end_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_letter_q <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (sym_valid_i) begin
            unique case (tmd_sym_e'(symbol_i))
              SYM_DOT, SYM_DASH: begin
                if (pend_len_q < LengthW'(SymLimit)) begin
                  if (tmd_sym_e'(symbol_i) == SYM_DASH) begin
                    pend_pat_q <= pend_pat_q | (PatternW'(1) << pend_len_q);
                  end
                  pend_len_q <= pend_len_q + LengthW'(1);
                end else begin
                  ovf_q <= 1'b1;
                end
              end
              SYM_SEP, SYM_END: begin
                if ((pend_len_q != '0) || ovf_q) begin
                  end_q <= (tmd_sym_e'(symbol_i) == SYM_END);
                  if (ovf_q) begin
                    res_q   <= UNKNOWN_CODE;
                    state_q <= ST_WAIT;
                  end else begin
                    ra_q    <= '0;
                    cmp_q   <= 1'b0;
                    state_q <= ST_SCAN;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          // read of entry ra_q issued now, its data compared next cycle
          cmp_q <= ra_in_table;
          if (ra_in_table) begin
            ra_q <= ra_q + CntW'(1);
          end
          if (cmp_q && hit) begin
            res_q   <= rd_i.entry.letter;
            state_q <= ST_WAIT;
          end else if (!cmp_q && !ra_in_table) begin
            res_q   <= UNKNOWN_CODE;
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (out_load) begin
            out_letter_q <= res_q;
            out_last_q   <= end_q;
            pend_pat_q   <= '0;
            pend_len_q   <= '0;
            ovf_q        <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o   = (state_q == ST_IDLE);
  assign rd_addr_o    = ra_q[IdxW-1:0];
  assign out_valid_o  = out_valid_q;
  assign out_letter_o = out_letter_q;
  assign out_last_o   = out_last_q;

endmodule

`default_nettype wire

[sv/table_driven_morse_decoder_core.sv]
// top level of the table-driven morse decoder: stream ports and field unpacking
// depends on tmd_pkg, tmd_table and tmd_ctrl
`default_nettype none

// Decodes a stream of dots, dashes, separators and end marks against a loadable
// code table. A table-write beat (tuser = 0) stores letter, pattern and length
// at one entry; a length of zero clears the entry's valid mark. A separator
// or end mark that closes a nonempty token starts a scan of the table through
// its single read port, one entry per cycle, stopping at the first valid match.
// After the flush beat tready stays low while the scan runs and while the
// result waits for the output register to drain; a token that overflowed the
// symbol limit skips the scan and is unknown. The letter (26 when unknown)
// leaves on the master port with tlast set when the token was closed by an end
// mark. An output register lets the next beat be taken while a result still
// waits.

module table_driven_morse_decoder_core
  import tmd_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned MAX_SYMBOLS   = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // entry_index[5:0], entry_letter[10:6], entry_pattern[42:11],
  // entry_length[48:43], symbol[50:49], zero fill[55:51]
  input  wire logic [55:0] s_axis_tdata_i,
  // req_type[0]
  input  wire logic [0:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // letter_code[4:0], zero fill[7:5]
  output logic [7:0]       m_axis_tdata_o,
  output logic             m_axis_tlast_o
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic               beat_in;
  logic               sym_valid;
  tmd_wr_t            wr;
  logic [IdxW-1:0]    rd_addr;
  tmd_rd_t            rd;
  logic [LetterW-1:0] out_letter;

  assign beat_in   = s_axis_tvalid_i && s_axis_tready_o;
  assign sym_valid = beat_in && (s_axis_tuser_i[0] == REQ_SYMBOL);

  always_comb begin
    wr.en      = beat_in && (s_axis_tuser_i[0] == REQ_WRITE);
    wr.idx     = s_axis_tdata_i[5:0];
    wr.letter  = s_axis_tdata_i[10:6];
    wr.pattern = s_axis_tdata_i[42:11];
    wr.length  = s_axis_tdata_i[48:43];
  end

  tmd_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .rd_addr_i(rd_addr),
    .rd_o     (rd)
  );

  tmd_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .MAX_SYMBOLS  (MAX_SYMBOLS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ready_o  (s_axis_tready_o),
    .sym_valid_i (sym_valid),
    .symbol_i    (s_axis_tdata_i[50:49]),
    .rd_addr_o   (rd_addr),
    .rd_i        (rd),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_letter_o(out_letter),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {3'b000, out_letter};

endmodule

`default_nettype wire
